// ----- sv/base64_stream_encoder_top_assert.svh -----
// Assertion macros shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_TOP_ASSERT_SVH
`define BASE64_STREAM_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define B64E_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b64e assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define B64E_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64e assertion failed");

`endif

// ----- sv/b64e_pkg.sv -----
// Shared types, constants and the alphabet lookup of the base64 encoder.
`default_nettype none

package b64e_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [3:0]      pad;
    logic [3:0][5:0] code;
    logic [1:0]      last_idx;
    logic            msg_end;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    case (v) inside
      [6'd0:6'd25]:  r = 8'h41 + w;
      [6'd26:6'd51]: r = 8'h61 + w - 8'd26;
      [6'd52:6'd61]: r = 8'h30 + w - 8'd52;
      6'd62:         r = 8'h2B;
      default:       r = 8'h2F;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/b64e_front.sv -----
// Front end: takes bytes, tracks group position and leftover bits, builds jobs.
`default_nettype none

module b64e_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          is_final_i,
  input  wire logic          q_full_i,
  output logic               full_o,
  output logic               q_push_o,
  output b64e_pkg::job_t     q_job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic       xfer;

  assign xfer     = push_i && !q_full_i;
  assign full_o   = q_full_i;
  assign q_push_o = xfer;

  always_comb begin
    q_job_o         = '0;
    q_job_o.msg_end = is_final_i;
    phase_d         = phase_q;
    carry_d         = carry_q;
    case (phase_q)
      2'd1: begin
        q_job_o.code[0] = {carry_q[1:0], data_byte_i[7:4]};
        q_job_o.code[1] = {data_byte_i[3:0], 2'b00};
        q_job_o.pad     = 4'b0100;
        if (is_final_i) begin
          q_job_o.last_idx = 2'd2;
          phase_d          = 2'd0;
          carry_d          = '0;
        end else begin
          q_job_o.last_idx = 2'd0;
          phase_d          = 2'd2;
          carry_d          = data_byte_i[3:0];
        end
      end
      2'd2: begin
        q_job_o.code[0]  = {carry_q, data_byte_i[7:6]};
        q_job_o.code[1]  = data_byte_i[5:0];
        q_job_o.last_idx = 2'd1;
        phase_d          = 2'd0;
        carry_d          = '0;
      end
      default: begin
        q_job_o.code[0] = data_byte_i[7:2];
        q_job_o.code[1] = {data_byte_i[1:0], 4'b0000};
        q_job_o.pad     = 4'b1100;
        if (is_final_i) begin
          q_job_o.last_idx = 2'd3;
          phase_d          = 2'd0;
          carry_d          = '0;
        end else begin
          q_job_o.last_idx = 2'd0;
          phase_d          = 2'd1;
          carry_d          = {2'b00, data_byte_i[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      carry_q <= '0;
    end else if (xfer) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/b64e_queue.sv -----
// Short job queue between front and back ends.
`default_nettype none

module b64e_queue #(
  parameter int unsigned Depth = b64e_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire b64e_pkg::job_t push_job_i,
  output logic               full_o,
  input  wire logic          take_i,
  output logic               valid_o,
  output b64e_pkg::job_t     job_o
);

  `include "base64_stream_encoder_top_assert.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64e_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr, rd;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign wr      = push_i && !full_o;
  assign rd      = take_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd && !wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  `B64E_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= FullCnt)
  `B64E_ASSERT_NXT(a_cnt_track, wr && !rd, cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

// ----- sv/b64e_back.sv -----
// Back end: walks jobs one char per cycle into output reg unless pop stalls.
`default_nettype none

module b64e_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire b64e_pkg::job_t q_job_i,
  output logic                q_take_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [7:0]          ascii_char_o,
  output logic                char_last_o
);

  `include "base64_stream_encoder_top_assert.svh"

  b64e_pkg::job_t job_q;
  logic           job_valid_q, job_valid_d;
  logic [1:0]     idx_q;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_char_q, char_d;
  logic           out_last_q;
  logic           load_out, done;

  assign load_out = job_valid_q && (!out_valid_q || pop_i);
  assign done     = load_out && (idx_q == job_q.last_idx);
  assign q_take_o = q_valid_i && (!job_valid_q || done);
  assign char_d   = job_q.pad[idx_q] ? b64e_pkg::PadChar
                                     : b64e_pkg::enc_char(job_q.code[idx_q]);

  always_comb begin
    job_valid_d = job_valid_q;
    if (q_take_o) begin
      job_valid_d = 1'b1;
    end else if (done) begin
      job_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_take_o) begin
      job_q <= q_job_i;
    end
    if (load_out) begin
      out_char_q <= char_d;
      out_last_q <= job_q.msg_end && (idx_q == job_q.last_idx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
      if (done) begin
        idx_q <= '0;
      end else if (load_out) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign ascii_char_o = out_char_q;
  assign char_last_o  = out_last_q;

  `B64E_ASSERT_IMP(a_idx_bound, job_valid_q, idx_q <= job_q.last_idx)
  `B64E_ASSERT_IMP(a_no_early_pad, job_valid_q, job_q.pad[1:0] == 2'b00)
  `B64E_ASSERT_NXT(a_job_retire, done && !q_valid_i, !job_valid_q && idx_q == 2'd0)

endmodule

`default_nettype wire

// ----- sv/base64_stream_encoder_top.sv -----
// Top level of the streaming base64 encoder (standard alphabet, padded).
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------
//   bytes   | in  | push / full          | data_byte_i, is_final_i
//   chars   | out | empty / pop          | ascii_char_o, char_last_o
//
// A byte is taken every cycle while the job queue has room; each byte makes
// one to four characters, and the output register gives one per cycle while pop is held.
// Sustained byte rate is set by the character port, which must carry the
// characters each byte makes (one to four, about 1.33 on long messages).
// First character of a byte passes through the queue entry, the job register and the output register.
// Reset clears group position, queue and output; no clearing pass.
// Holding pop low stalls only the back end; the front keeps filling the queue until it is full.
`default_nettype none

module base64_stream_encoder_top #(
  parameter int unsigned QueueDepth = b64e_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       is_final_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      ascii_char_o,
  output logic            char_last_o
);

  b64e_pkg::job_t fe_job, q_job;
  logic           fe_push, q_full, q_valid, q_take;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .is_final_i  (is_final_i),
    .q_full_i    (q_full),
    .full_o      (full),
    .q_push_o    (fe_push),
    .q_job_o     (fe_job)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fe_push),
    .push_job_i (fe_job),
    .full_o     (q_full),
    .take_i     (q_take),
    .valid_o    (q_valid),
    .job_o      (q_job)
  );

  b64e_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_job_i      (q_job),
    .q_take_o     (q_take),
    .pop_i        (pop),
    .empty_o      (empty),
    .ascii_char_o (ascii_char_o),
    .char_last_o  (char_last_o)
  );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the streaming base64 encoder: random messages, stalls, char scoreboard.
`default_nettype none

module testbench;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned HoldCycles = 90;
  localparam int unsigned TailCycles = 16;
  localparam int unsigned ByteTarget = 480;

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2
  } group_pos_e;

  typedef struct packed {
    logic [7:0] code;
    logic       ends_msg;
  } b64_char_t;

  class char_scoreboard;
    string       alphabet;
    group_pos_e  pos;
    logic [3:0]  carry;
    b64_char_t   pending_chars[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned ends_at[3];

    function new();
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      pos = POS_FIRST;
      carry = '0;
      errors = 0;
      checked = 0;
      ends_at = '{0, 0, 0};
    endfunction

    function void report(string msg);
      if (errors < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void add_char(logic [7:0] c, logic e);
      pending_chars.push_back('{code: c, ends_msg: e});
    endfunction

    function logic [7:0] sextet(logic [5:0] v);
      return alphabet[v];
    endfunction

    // Accepted byte: predict the characters it releases.
    function void note_byte(logic [7:0] b, logic fin);
      if (fin) ends_at[(pos == POS_THIRD) ? 2 : (pos == POS_SECOND) ? 1 : 0]++;
      case (pos)
        POS_SECOND: begin
          add_char(sextet({carry[1:0], b[7:4]}), 1'b0);
          if (fin) begin
            add_char(sextet({b[3:0], 2'b00}), 1'b0);
            add_char(b64e_pkg::PadChar, 1'b1);
            pos = POS_FIRST;
            carry = '0;
          end else begin
            carry = b[3:0];
            pos = POS_THIRD;
          end
        end
        POS_THIRD: begin
          add_char(sextet({carry, b[7:6]}), 1'b0);
          add_char(sextet(b[5:0]), fin);
          pos = POS_FIRST;
          carry = '0;
        end
        default: begin
          add_char(sextet(b[7:2]), 1'b0);
          if (fin) begin
            add_char(sextet({b[1:0], 4'b0000}), 1'b0);
            add_char(b64e_pkg::PadChar, 1'b0);
            add_char(b64e_pkg::PadChar, 1'b1);
            pos = POS_FIRST;
            carry = '0;
          end else begin
            carry = {2'b00, b[1:0]};
            pos = POS_SECOND;
          end
        end
      endcase
    endfunction

    function void check_char(logic [7:0] c, logic e);
      b64_char_t exp_c;
      if (pending_chars.size() == 0) begin
        report($sformatf("char %02h last=%b with nothing expected", c, e));
        return;
      end
      exp_c = pending_chars.pop_front();
      checked++;
      if (c !== exp_c.code)
        report($sformatf("ascii_char_o %02h, expected %02h", c, exp_c.code));
      if (e !== exp_c.ends_msg)
        report($sformatf("char_last_o %b, expected %b", e, exp_c.ends_msg));
    endfunction

    function int unsigned pending();
      return pending_chars.size();
    endfunction

    function void check_leftover();
      if (pending_chars.size() != 0)
        report($sformatf("%0d chars never arrived", pending_chars.size()));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       push;
  logic       full;
  logic [7:0] data_byte;
  logic       is_final;
  logic       empty;
  logic       pop;
  logic [7:0] ascii_char;
  logic       char_last;

  char_scoreboard sb;
  bit             tx_steady;
  bit             rx_steady;
  int unsigned    stall_cycles;
  int unsigned    msgs_sent;
  int unsigned    bytes_sent;

  base64_stream_encoder_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .is_final_i  (is_final),
    .empty       (empty),
    .pop         (pop),
    .ascii_char_o(ascii_char),
    .char_last_o (char_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Transfer monitor and idle watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_byte(data_byte, is_final);
      if (pop && !empty) sb.check_char(ascii_char, char_last);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles == StallLimit) begin
        $display("TIMEOUT: no transfer for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= b;
    is_final  <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    if (fin) msgs_sent++;
  endtask

  task automatic take_char();
    int unsigned gap;
    gap = rx_steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      pop <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pop <= 1'b1;
    @(posedge clk_i);
    while (empty) @(posedge clk_i);
  endtask

  task automatic send_msg(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Receiver: random gaps, steady stretches, two long hold-offs to back up the queue.
  initial begin
    int unsigned n_taken;
    n_taken = 0;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (n_taken % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (n_taken == 60 || n_taken == 400) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      take_char();
      n_taken++;
    end
  end

  initial begin
    logic [7:0] msg[$];
    int unsigned len;
    int unsigned sel;
    sb = new();
    stall_cycles = 0;
    msgs_sent = 0;
    bytes_sent = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rst_ni    <= 1'b0;
    push      <= 1'b0;
    data_byte <= '0;
    is_final  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: final byte in each group position, extreme bytes, '+' and '/'.
    send_msg('{8'h00});
    send_msg('{8'hFF});
    send_msg('{8'hFF, 8'h00});
    send_msg('{8'h00, 8'hFF});
    send_msg('{8'hFB, 8'hEF, 8'hBE});
    send_msg('{8'hFF, 8'hFF, 8'hFF, 8'h4D});
    send_msg('{8'h4D, 8'h61, 8'h6E});

    // Random messages, mostly short, now and then long.
    while (bytes_sent < ByteTarget) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      msg.delete();
      repeat (len) begin
        sel = $urandom_range(0, 7);
        msg.push_back(sel == 0 ? 8'h00 : sel == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      end
      send_msg(msg);
    end
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    sb.check_leftover();

    $display("Sent %0d messages in %0d bytes; %0d chars checked.",
             msgs_sent, bytes_sent, sb.checked);
    $display("Messages ending at group byte 0/1/2: %0d/%0d/%0d, with two output hold-offs.",
             sb.ends_at[0], sb.ends_at[1], sb.ends_at[2]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+sv
sv/b64e_pkg.sv
sv/b64e_front.sv
sv/b64e_queue.sv
sv/b64e_back.sv
sv/base64_stream_encoder_top.sv
bench/testbench.sv
